// ===== hw/rtl/dct8_pkg.sv =====
// ----------------------------------------------------------------------------
// dct8_pkg: shared types and constants for the 8x8 fixed-point DCT
// Holds the cosine basis table and the block-handoff descriptor type.
// ----------------------------------------------------------------------------
package dct8_pkg;

  localparam int unsigned BlkN    = 8;
  localparam int unsigned BlkSize = 64;
  localparam int unsigned AddrW   = 6;
  localparam int unsigned SampleW = 16;
  localparam int unsigned RowW    = 18;
  localparam int unsigned CoefW   = 20;
  localparam int unsigned BasisW  = 17;

  // Descriptor of one loaded block handed from the front end to the back end.
  typedef struct packed {
    logic bank;
  } blk_desc_t;

  // Basis row k (1..7) at input n; k = 0 handled separately (plain sum).
  function automatic logic signed [BasisW-1:0] basis(input logic [2:0] k,
                                                     input logic [2:0] n);
    logic signed [BasisW-1:0] c1, c2, c3, c4, c6, c7;
    logic signed [BasisW-1:0] r;
    begin
      c1 = 17'sd32138; c2 = 17'sd30273; c3 = 17'sd27245;
      c4 = 17'sd23170; c6 = 17'sd12539; c7 = 17'sd18204;
      r  = '0;
      case (k)
        3'd1: begin
          case (n)
            3'd0: r = c1;   3'd1: r = c3;   3'd2: r = c7;  3'd3: r = 17'sd6392;
            3'd4: r = -17'sd6392; 3'd5: r = -c7; 3'd6: r = -c3;
            default: r = -c1;
          endcase
        end
        3'd2: begin
          case (n)
            3'd0, 3'd7: r = c2;
            3'd1, 3'd6: r = c6;
            3'd2, 3'd5: r = -c6;
            default: r = -c2;
          endcase
        end
        3'd3: begin
          case (n)
            3'd0: r = c3; 3'd1: r = -17'sd6392; 3'd2: r = -c1; 3'd3: r = -c7;
            3'd4: r = c7; 3'd5: r = c1; 3'd6: r = 17'sd6392;
            default: r = -c3;
          endcase
        end
        3'd4: begin
          case (n)
            3'd0, 3'd3, 3'd4, 3'd7: r = c4;
            default: r = -c4;
          endcase
        end
        3'd5: begin
          case (n)
            3'd0: r = c7; 3'd1: r = -c1; 3'd2: r = 17'sd6392; 3'd3: r = c3;
            3'd4: r = -c3; 3'd5: r = -17'sd6392; 3'd6: r = c1;
            default: r = -c7;
          endcase
        end
        3'd6: begin
          case (n)
            3'd0, 3'd3, 3'd4, 3'd7: r = (n == 3'd0 || n == 3'd7) ? c6 : -c6;
            3'd1, 3'd6: r = -c2;
            default: r = c2;
          endcase
        end
        3'd7: begin
          case (n)
            3'd0: r = 17'sd6392; 3'd1: r = -c7; 3'd2: r = c3; 3'd3: r = -c1;
            3'd4: r = c1; 3'd5: r = -c3; 3'd6: r = c7;
            default: r = -17'sd6392;
          endcase
        end
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== hw/rtl/dct8_front.sv =====
// ----------------------------------------------------------------------------
// dct8_front: sample loader
// Writes samples into a ping-pong pair of sample banks and posts a
// descriptor for each completed block into a two-entry queue.
// ----------------------------------------------------------------------------
module dct8_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sample_valid_i,
  output logic                        sample_ready_o,
  input  logic [dct8_pkg::SampleW-1:0] sample_i,
  // write port to sample banks
  output logic                        wr_en_o,
  output logic [dct8_pkg::AddrW:0]    wr_addr_o,
  output logic [dct8_pkg::SampleW-1:0] wr_data_o,
  // descriptor queue
  output logic                        desc_valid_o,
  input  logic                        desc_ready_i,
  output dct8_pkg::blk_desc_t         desc_o,
  // bank freed by back end
  input  logic                        bank_free_i
);

  logic [dct8_pkg::AddrW-1:0] load_count_q, load_count_d;
  logic                       bank_q, bank_d;
  logic [1:0]                 busy_q, busy_d;   // banks holding a block
  logic [1:0]                 qcnt_q, qcnt_d;
  logic [1:0]                 qbank_q, qbank_d;
  logic                       qhead_q, qhead_d;
  logic                       acc;
  logic                       push, pop;

  assign sample_ready_o = !busy_q[bank_q];
  assign acc       = sample_valid_i && sample_ready_o;
  assign push      = acc && (load_count_q == '1);
  assign pop       = desc_valid_o && desc_ready_i;
  assign wr_en_o   = acc;
  assign wr_addr_o = {bank_q, load_count_q};
  assign wr_data_o = sample_i;
  assign desc_valid_o = (qcnt_q != 2'd0);
  assign desc_o.bank  = qbank_q[qhead_q];

  always_comb begin
    load_count_d = load_count_q;
    bank_d       = bank_q;
    busy_d       = busy_q;
    qcnt_d       = qcnt_q;
    qbank_d      = qbank_q;
    qhead_d      = qhead_q;
    if (acc) begin
      load_count_d = load_count_q + 1'b1;
    end
    if (pop) begin
      qhead_d = !qhead_q;
    end
    if (bank_free_i) begin
      busy_d[!bank_q ^ busy_q[bank_q]] = 1'b0;
    end
    if (push) begin
      busy_d[bank_q]             = 1'b1;
      qbank_d[qhead_q ^ qcnt_q[0]] = bank_q;
      bank_d                     = !bank_q;
    end
    qcnt_d = qcnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_count_q <= '0;
      bank_q       <= 1'b0;
      busy_q       <= '0;
      qcnt_q       <= '0;
      qbank_q      <= '0;
      qhead_q      <= 1'b0;
    end else begin
      load_count_q <= load_count_d;
      bank_q       <= bank_d;
      busy_q       <= busy_d;
      qcnt_q       <= qcnt_d;
      qbank_q      <= qbank_d;
      qhead_q      <= qhead_d;
    end
  end

endmodule

// ===== hw/rtl/dct8_back.sv =====
// ----------------------------------------------------------------------------
// dct8_back: transform engine
// Runs the row pass then the column pass of one block with one shared
// multiply-accumulate unit, and streams coefficients through an output reg.
// ----------------------------------------------------------------------------
module dct8_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          desc_valid_i,
  output logic                          desc_ready_o,
  input  dct8_pkg::blk_desc_t           desc_i,
  output logic                          bank_free_o,
  input  logic                          wr_en_i,
  input  logic [dct8_pkg::AddrW:0]      wr_addr_i,
  input  logic [dct8_pkg::SampleW-1:0]  wr_data_i,
  output logic                          coef_valid_o,
  input  logic                          coef_ready_i,
  output logic [dct8_pkg::CoefW-1:0]    coef_o,
  output logic                          last_o
);

  typedef enum logic [1:0] {S_IDLE, S_ROW, S_COL, S_OUT} state_e;

  logic [dct8_pkg::SampleW-1:0] smem [0:2*dct8_pkg::BlkSize-1];
  logic [dct8_pkg::RowW-1:0]    rmem [0:dct8_pkg::BlkSize-1];
  logic [dct8_pkg::RowW-1:0]    rmem_wdata;
  logic                         rmem_we;
  logic [dct8_pkg::AddrW-1:0]   rmem_waddr;

  state_e                       state_q;
  logic                         bank_q;
  logic [2:0]                   line_q, k_q, n_q;   // line, output index, tap
  logic                         rd_v_q;             // read data valid for mac
  logic [2:0]                   rd_k_q, rd_n_q, rd_line_q;
  logic                         rd_is_col_q, p_is_col_q;
  logic signed [dct8_pkg::SampleW-1:0] s_rd_q;
  logic signed [dct8_pkg::RowW-1:0]    r_rd_q;
  logic signed [dct8_pkg::BasisW-1:0]  b_q;
  logic signed [34:0]           prod_q;
  logic                         pv_q;
  logic [2:0]                   p_k_q, p_n_q, p_line_q;
  logic signed [39:0]           acc_q;
  logic [dct8_pkg::CoefW-1:0]   col_buf_q [0:dct8_pkg::BlkSize-1];
  logic [dct8_pkg::AddrW-1:0]   out_idx_q;
  logic                         drain_q;             // mac pipeline still busy
  logic [1:0]                   drain_cnt_q;
  logic                         is_col;
  logic                         issue_done;
  logic signed [39:0]           acc_next;
  logic signed [39:0]           res;
  logic [dct8_pkg::AddrW-1:0]   ridx;

  assign is_col       = (state_q == S_COL);
  assign desc_ready_o = (state_q == S_IDLE);
  assign issue_done   = (line_q == 3'd7) && (k_q == 3'd7) && (n_q == 3'd7);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) smem[wr_addr_i] <= wr_data_i;
  end

  // Stage 1: read operands.
  always_ff @(posedge clk_i) begin
    s_rd_q <= smem[{bank_q, line_q, n_q}];
    r_rd_q <= rmem[{n_q, line_q}];
    b_q    <= (k_q == 3'd0) ? 17'sd1 : dct8_pkg::basis(k_q, n_q);
  end

  // Stage 2: multiply.
  always_ff @(posedge clk_i) begin
    if (rd_is_col_q) prod_q <= 35'(r_rd_q * b_q);
    else             prod_q <= 35'(s_rd_q * b_q);
  end

  // Stage 3: accumulate and write back.
  assign acc_next = (p_n_q == 3'd0) ? 40'(prod_q) : acc_q + 40'(prod_q);
  assign res      = (p_k_q == 3'd0) ? (acc_next >>> 3) : (acc_next >>> 16);
  assign ridx     = {p_k_q, p_line_q};

  always_ff @(posedge clk_i) begin
    if (pv_q) acc_q <= acc_next;
    rmem_we    <= pv_q && (p_n_q == 3'd7) && !p_is_col_q;
    rmem_waddr <= {p_line_q, p_k_q};
    rmem_wdata <= res[dct8_pkg::RowW-1:0];
    if (pv_q && (p_n_q == 3'd7) && p_is_col_q) begin
      col_buf_q[ridx] <= res[dct8_pkg::CoefW-1:0];
    end
    if (rmem_we) rmem[rmem_waddr] <= rmem_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bank_q      <= 1'b0;
      line_q      <= '0;
      k_q         <= '0;
      n_q         <= '0;
      rd_v_q      <= 1'b0;
      pv_q        <= 1'b0;
      rd_is_col_q <= 1'b0;
      p_is_col_q  <= 1'b0;
      rd_k_q      <= '0;
      rd_n_q      <= '0;
      rd_line_q   <= '0;
      p_k_q       <= '0;
      p_n_q       <= '0;
      p_line_q    <= '0;
      drain_q     <= 1'b0;
      drain_cnt_q <= '0;
      out_idx_q   <= '0;
      coef_valid_o <= 1'b0;
      coef_o      <= '0;
      last_o      <= 1'b0;
      bank_free_o <= 1'b0;
    end else begin
      bank_free_o <= 1'b0;
      rd_v_q      <= (state_q == S_ROW || state_q == S_COL) && !drain_q;
      rd_is_col_q <= is_col;
      rd_k_q      <= k_q;
      rd_n_q      <= n_q;
      rd_line_q   <= line_q;
      pv_q        <= rd_v_q;
      p_is_col_q  <= rd_is_col_q;
      p_k_q       <= rd_k_q;
      p_n_q       <= rd_n_q;
      p_line_q    <= rd_line_q;
      case (state_q)
        S_IDLE: begin
          if (desc_valid_i) begin
            bank_q  <= desc_i.bank;
            state_q <= S_ROW;
            {line_q, k_q, n_q} <= '0;
          end
        end
        S_ROW, S_COL: begin
          if (drain_q) begin
            // let the last results (and row write) land
            drain_cnt_q <= drain_cnt_q + 1'b1;
            if (drain_cnt_q == 2'd3) begin
              drain_q <= 1'b0;
              if (state_q == S_ROW) begin
                state_q     <= S_COL;
                bank_free_o <= 1'b1;
              end else begin
                state_q   <= S_OUT;
                out_idx_q <= '0;
              end
            end
          end else begin
            {line_q, k_q, n_q} <= {line_q, k_q, n_q} + 9'd1;
            if (issue_done) begin
              drain_q     <= 1'b1;
              drain_cnt_q <= '0;
            end
          end
        end
        S_OUT: begin
          if (!coef_valid_o || coef_ready_i) begin
            coef_valid_o <= 1'b1;
            coef_o       <= col_buf_q[out_idx_q];
            last_o       <= (out_idx_q == '1);
            out_idx_q    <= out_idx_q + 1'b1;
            if (out_idx_q == '1) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q != S_OUT && coef_valid_o && coef_ready_i) begin
        coef_valid_o <= 1'b0;
        last_o       <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/dct_8x8_fixed_point.sv =====
// Each block runs a row pass and then a column pass in the transform engine
// (512 row MACs + 512 column MACs on one shared multiplier, plus drain).
// Block throughput is set by the single MAC unit; samples load one per cycle into
// a ping-pong bank while the previous block runs, and stall while that bank holds a block.
// Reset: asynchronous, active low; clears counters, queue and engine state.
// ----------------------------------------------------------------------------
// dct_8x8_fixed_point: 8x8 two-dimensional fixed-point DCT-II
// Loads samples row-major and streams 64 coefficients row-major per block.
// ----------------------------------------------------------------------------
module dct_8x8_fixed_point (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sample_valid_i,
  output logic        sample_ready_o,
  input  logic [15:0] sample_i,
  output logic        coef_valid_o,
  input  logic        coef_ready_i,
  output logic [19:0] coefficient_o,
  output logic        last_of_block_o
);

  logic                  wr_en;
  logic [6:0]            wr_addr;
  logic [15:0]           wr_data;
  logic                  desc_valid, desc_ready, bank_free;
  dct8_pkg::blk_desc_t   desc;

  dct8_front u_front (
    .clk_i, .rst_ni, .sample_valid_i,
    .sample_ready_o, .sample_i,
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .desc_valid_o(desc_valid), .desc_ready_i(desc_ready), .desc_o(desc),
    .bank_free_i(bank_free)
  );

  dct8_back u_back (
    .clk_i, .rst_ni,
    .desc_valid_i(desc_valid), .desc_ready_o(desc_ready), .desc_i(desc),
    .bank_free_o(bank_free),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .coef_valid_o, .coef_ready_i, .coef_o(coefficient_o), .last_o(last_of_block_o)
  );

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_valid_o && !coef_ready_i |=> coef_valid_o && $stable(coefficient_o))
    else $error("coefficient dropped while stalled");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_block_o |-> coef_valid_o)
    else $error("last flag without valid");

endmodule
